@@ sv/fft_wavevector_from_index_core_macros.svh @@
// ----------------------------------------------------------------------------
// fft_wavevector_from_index_core_macros
// Assertion macros for the wavevector generator.
// ----------------------------------------------------------------------------
`ifndef FFT_WAVEVECTOR_FROM_INDEX_CORE_MACROS_SVH
`define FFT_WAVEVECTOR_FROM_INDEX_CORE_MACROS_SVH
`ifndef SYNTH
`define FWV_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define FWV_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define FWV_ASSERT_IMPL(label, clk, rst_n, a, c)
`define FWV_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ sv/fwv_pkg.sv @@
// ----------------------------------------------------------------------------
// fwv_pkg
// Shared types and constants of the wavevector generator.
// ----------------------------------------------------------------------------
package fwv_pkg;
    localparam int unsigned SIZE_W  = 11;
    localparam int unsigned COORD_W = 10;
    localparam int unsigned IDX_W   = 30;
    localparam int unsigned SCALE_W = 24;
    localparam int unsigned WAVE_W  = 34;
    localparam int unsigned SQ_W    = 52;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X   = 3'd0,
        REG_SIZE_Y   = 3'd1,
        REG_SIZE_Z   = 3'd2,
        REG_SLAB_OFS = 3'd3,
        REG_SCALE_X  = 3'd4,
        REG_SCALE_Y  = 3'd5,
        REG_SCALE_Z  = 3'd6,
        REG_NYQ_KILL = 3'd7
    } t_cfg_reg;

    // per-axis result of the map stage
    typedef struct packed {
        logic signed [COORD_W-1:0] freq;
        logic                      nyq;
    } t_axis;
endpackage

@@ sv/fwv_divmod.sv @@
// ----------------------------------------------------------------------------
// fwv_divmod
// Pipelined restoring divider: one quotient bit per stage, N_BITS stages.
// Carries a side word along so the caller can keep context aligned.
// ----------------------------------------------------------------------------
module fwv_divmod #(
    parameter int unsigned N_BITS = 30,
    parameter int unsigned D_BITS = 11,
    parameter int unsigned S_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [N_BITS-1:0] i_num,
    input  logic [D_BITS-1:0] i_den,
    input  logic [S_BITS-1:0] i_side,
    output logic              o_valid,
    output logic [N_BITS-1:0] o_quot,
    output logic [D_BITS-1:0] o_rem,
    output logic [S_BITS-1:0] o_side
);
    logic [N_BITS:0]   r_v;
    logic [N_BITS-1:0] r_q   [N_BITS+1];
    logic [D_BITS-1:0] r_r   [N_BITS+1];
    logic [D_BITS-1:0] r_d   [N_BITS+1];
    logic [S_BITS-1:0] r_s   [N_BITS+1];

    assign r_v[0] = i_valid;
    assign r_q[0] = i_num;
    assign r_r[0] = '0;
    assign r_d[0] = i_den;
    assign r_s[0] = i_side;

    for (genvar k = 0; k < N_BITS; k++) begin : g_stage
        logic [D_BITS:0]   n_trial;
        logic              n_ge;
        always_comb begin
            n_trial = {r_r[k], r_q[k][N_BITS-1]};
            n_ge    = n_trial >= {1'b0, r_d[k]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_r[k+1] <= n_ge ? D_BITS'(n_trial - {1'b0, r_d[k]}) : D_BITS'(n_trial);
                r_q[k+1] <= {r_q[k][N_BITS-2:0], n_ge};
                r_d[k+1] <= r_d[k];
                r_s[k+1] <= r_s[k];
            end
        end
    end

    assign o_valid = r_v[N_BITS];
    assign o_quot  = r_q[N_BITS];
    assign o_rem   = r_r[N_BITS];
    assign o_side  = r_s[N_BITS];
endmodule

@@ sv/fft_wavevector_from_index_core.sv @@
// ----------------------------------------------------------------------------
// fft_wavevector_from_index_core
// Grid index to frequency index, wavevector and squared magnitude.
// ----------------------------------------------------------------------------
// One word in per cycle and one result out per cycle while the pipe is not
// held: three 30-stage bit-per-stage dividers split the index along x and
// y and reduce z, an 11-stage divider folds the slab offset into the last
// axis, then frequency map, scale multiply, a two-stage square pipeline and
// the output register follow. The whole pipe advances together; it holds
// while the output register is full and not taken. Configure only when idle.
`include "fft_wavevector_from_index_core_macros.svh"
module fft_wavevector_from_index_core #(
    parameter int unsigned DIMS     = 3,
    parameter int unsigned MAX_SIDE = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_idx,
    input  logic [23:0]                       i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [fwv_pkg::IDX_W-1:0]         i_local_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [9:0]                 o_freq_x,
    output logic signed [9:0]                 o_freq_y,
    output logic signed [9:0]                 o_freq_z,
    output logic signed [fwv_pkg::WAVE_W-1:0] o_wave_x,
    output logic signed [fwv_pkg::WAVE_W-1:0] o_wave_y,
    output logic signed [fwv_pkg::WAVE_W-1:0] o_wave_z,
    output logic [fwv_pkg::SQ_W-1:0]          o_wave_sq
);
    import fwv_pkg::*;

    // ---------------- configuration ----------------
    logic [SIZE_W-1:0]  r_size [3];
    logic [9:0]         r_ofs;
    logic [SCALE_W-1:0] r_scale [3];
    logic               r_kill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size[0] <= 11'd64; r_size[1] <= 11'd64; r_size[2] <= 11'd64;
            r_ofs <= '0;
            r_scale[0] <= 24'd65536; r_scale[1] <= 24'd65536; r_scale[2] <= 24'd65536;
            r_kill <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_SIZE_X:   r_size[0]  <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:   r_size[1]  <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Z:   r_size[2]  <= i_cfg_data[SIZE_W-1:0];
                REG_SLAB_OFS: r_ofs      <= i_cfg_data[9:0];
                REG_SCALE_X:  r_scale[0] <= i_cfg_data;
                REG_SCALE_Y:  r_scale[1] <= i_cfg_data;
                REG_SCALE_Z:  r_scale[2] <= i_cfg_data;
                REG_NYQ_KILL: r_kill     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective sizes, unused axes become 1 so they give coordinate 0
    logic [SIZE_W-1:0] w_sz [3];
    always_comb begin
        for (int d = 0; d < 3; d++) begin
            if (r_size[d] == '0) w_sz[d] = SIZE_W'(1);
            else if (r_size[d] > SIZE_W'(MAX_SIDE)) w_sz[d] = SIZE_W'(MAX_SIDE);
            else w_sz[d] = r_size[d];
            if (d >= DIMS) w_sz[d] = SIZE_W'(1);
        end
    end

    // ---------------- pipe control ----------------
    logic w_en;
    logic r_out_v;
    assign w_en    = !r_out_v || i_ready;
    assign o_ready = w_en;

    // ---------------- x and y split ----------------
    logic              w_vx, w_vy;
    logic [IDX_W-1:0]  w_qx, w_qy;
    logic [SIZE_W-1:0] w_rx, w_ry;
    logic [SIZE_W-1:0] w_sx;

    fwv_divmod #(.N_BITS(IDX_W), .D_BITS(SIZE_W), .S_BITS(1)) u_div_x (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(i_valid),
        .i_num(i_local_index), .i_den(w_sz[0]), .i_side(1'b0),
        .o_valid(w_vx), .o_quot(w_qx), .o_rem(w_rx), .o_side()
    );

    fwv_divmod #(.N_BITS(IDX_W), .D_BITS(SIZE_W), .S_BITS(SIZE_W)) u_div_y (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_vx),
        .i_num(w_qx), .i_den(w_sz[1]), .i_side(w_rx),
        .o_valid(w_vy), .o_quot(w_qy), .o_rem(w_ry), .o_side(w_sx)
    );

    // ---------------- z: q_y mod n_z ----------------
    logic              w_vz;
    logic [SIZE_W-1:0] w_rz;
    logic [2*SIZE_W-1:0] w_sxy;
    fwv_divmod #(.N_BITS(IDX_W), .D_BITS(SIZE_W), .S_BITS(2*SIZE_W)) u_div_z (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_vy),
        .i_num(w_qy), .i_den(w_sz[2]), .i_side({w_sx, w_ry}),
        .o_valid(w_vz), .o_quot(), .o_rem(w_rz), .o_side(w_sxy)
    );

    // coordinate per axis; rem < n <= 1024.
    // The offset lands on axis DIMS-1: when DIMS<3 the later axes hold 0.
    logic [SIZE_W-1:0] w_c [3];
    always_comb begin
        w_c[0] = w_sxy[2*SIZE_W-1:SIZE_W];
        w_c[1] = w_sxy[SIZE_W-1:0];
        w_c[2] = w_rz;
    end

    // offset: (c + ofs) mod n on the last used axis; c + ofs < 2048
    logic                w_vm;
    logic [SIZE_W-1:0]   w_zsum;
    logic [SIZE_W-1:0]   w_rm;
    logic [3*SIZE_W-1:0] w_cm;
    assign w_zsum = w_c[DIMS-1] + SIZE_W'(r_ofs);

    fwv_divmod #(.N_BITS(SIZE_W), .D_BITS(SIZE_W), .S_BITS(3*SIZE_W)) u_mod_ofs (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_vz),
        .i_num(w_zsum), .i_den(w_sz[DIMS-1]), .i_side({w_c[0], w_c[1], w_c[2]}),
        .o_valid(w_vm), .o_quot(), .o_rem(w_rm), .o_side(w_cm)
    );

    // stage M: coordinates with the offset folded in
    logic              r_m_v;
    logic [SIZE_W-1:0] r_m_c [3];
    logic [SIZE_W-1:0] n_m_c [3];
    always_comb begin
        n_m_c[0] = w_cm[3*SIZE_W-1:2*SIZE_W];
        n_m_c[1] = w_cm[2*SIZE_W-1:SIZE_W];
        n_m_c[2] = w_cm[SIZE_W-1:0];
        n_m_c[DIMS-1] = w_rm;
    end

    // stage F: frequency map and Nyquist flag
    logic   r_f_v;
    t_axis  r_f_ax [3];
    logic   r_f_kill;
    t_axis  n_f_ax [3];
    logic   n_f_kill;
    always_comb begin
        logic [SIZE_W:0] twoc;
        logic [SIZE_W:0] f;
        n_f_kill = 1'b0;
        for (int d = 0; d < 3; d++) begin
            twoc = {r_m_c[d], 1'b0};
            n_f_ax[d].nyq = !w_sz[d][0] && (twoc == {1'b0, w_sz[d]}) && (d < DIMS);
            if (twoc < {1'b0, w_sz[d]}) f = {1'b0, r_m_c[d]};
            else f = {1'b0, r_m_c[d]} - {1'b0, w_sz[d]};
            n_f_ax[d].freq = COORD_W'(f);
            if (n_f_ax[d].nyq) n_f_kill = 1'b1;
        end
        n_f_kill = n_f_kill && r_kill;
    end

    // stage W: scale multiply (signed 10 x unsigned 24), zeroed on a Nyquist kill
    logic                     r_w_v;
    logic signed [COORD_W-1:0] r_w_f [3];
    logic signed [WAVE_W-1:0]  r_w_k [3];
    // stage S: split squares of |wave| into hi*hi, hi*lo, lo*lo
    logic                     r_s_v;
    logic signed [COORD_W-1:0] r_s_f [3];
    logic signed [WAVE_W-1:0]  r_s_k [3];
    logic [35:0]               r_s_hh [3];
    logic [35:0]               r_s_hl [3];
    logic [15:0]               r_s_ll [3];
    // stage T: per-axis square
    logic                     r_t_v;
    logic signed [COORD_W-1:0] r_t_f [3];
    logic signed [WAVE_W-1:0]  r_t_k [3];
    logic [SQ_W-1:0]           r_t_sq [3];

    logic [WAVE_W-1:0] w_abs [3];
    always_comb begin
        for (int d = 0; d < 3; d++)
            w_abs[d] = r_w_k[d][WAVE_W-1] ? WAVE_W'(-r_w_k[d]) : WAVE_W'(r_w_k[d]);
    end

    // output registers
    logic signed [COORD_W-1:0] r_o_f [3];
    logic signed [WAVE_W-1:0]  r_o_k [3];
    logic [SQ_W-1:0]           r_o_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0; r_f_v <= 1'b0; r_w_v <= 1'b0;
            r_s_v <= 1'b0; r_t_v <= 1'b0; r_out_v <= 1'b0;
        end else if (w_en) begin
            r_m_v <= w_vm; r_f_v <= r_m_v; r_w_v <= r_f_v;
            r_s_v <= r_w_v; r_t_v <= r_s_v; r_out_v <= r_t_v;
        end
        if (w_en) begin
            for (int d = 0; d < 3; d++) begin
                r_m_c[d] <= n_m_c[d];
                r_f_ax[d] <= n_f_ax[d];
                r_w_f[d] <= r_f_kill ? '0 : r_f_ax[d].freq;
                r_w_k[d] <= r_f_kill ? '0 :
                    WAVE_W'($signed(r_f_ax[d].freq) * $signed({1'b0, r_scale[d]}));
                r_s_f[d]  <= r_w_f[d];
                r_s_k[d]  <= r_w_k[d];
                r_s_hh[d] <= {18'd0, w_abs[d][WAVE_W-1:16]} * {18'd0, w_abs[d][WAVE_W-1:16]};
                r_s_hl[d] <= {18'd0, w_abs[d][WAVE_W-1:16]} * {20'd0, w_abs[d][15:0]};
                r_s_ll[d] <= 16'((32'(w_abs[d][15:0]) * 32'(w_abs[d][15:0])) >> 16);
                r_t_f[d]  <= r_s_f[d];
                r_t_k[d]  <= r_s_k[d];
                r_t_sq[d] <= SQ_W'({r_s_hh[d], 16'd0}) + SQ_W'({r_s_hl[d], 1'b0})
                           + SQ_W'(r_s_ll[d]);
                r_o_f[d]  <= r_t_f[d];
                r_o_k[d]  <= r_t_k[d];
            end
            r_f_kill <= n_f_kill;
            r_o_sq <= r_t_sq[0] + r_t_sq[1] + r_t_sq[2];
        end
    end

    assign o_valid   = r_out_v;
    assign o_freq_x  = r_o_f[0];
    assign o_freq_y  = r_o_f[1];
    assign o_freq_z  = r_o_f[2];
    assign o_wave_x  = r_o_k[0];
    assign o_wave_y  = r_o_k[1];
    assign o_wave_z  = r_o_k[2];
    assign o_wave_sq = r_o_sq;

    `FWV_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !r_out_v, o_ready)
    `FWV_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, r_out_v && !i_ready, $stable(r_o_sq))
    `FWV_ASSERT_IMPL(a_kill_zero, i_clk, i_rst_n, r_w_v && r_w_f[0] == '0, r_w_k[0] == '0)
endmodule

@@ sim/fft_wavevector_from_index_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fft_wavevector_from_index_core_tb
// Self-checking bench for the grid index to wavevector generator.
// Index words stream in with random gaps. The receiver stalls at random,
// including one long hold that backs the pipe up. Each result word is
// compared field by field against an in-order predictor. Register settings
// change between phases, covering size, offset, scale and Nyquist extremes.
// ----------------------------------------------------------------------------
module fft_wavevector_from_index_core_tb;
    import fwv_pkg::*;

    typedef struct {
        logic signed [9:0]        freq[3];
        logic signed [WAVE_W-1:0] wave[3];
        logic [SQ_W-1:0]          sq;
    } t_wv;

    class wavevector_scoreboard;
        int unsigned  side[3];
        longint       scale[3];
        int unsigned  z_ofs;
        bit           nyq_zero;
        t_wv          pending[$];
        int unsigned  errors;

        function new();
            side  = '{64, 64, 64};
            scale = '{65536, 65536, 65536};
            z_ofs = 0;
            nyq_zero = 0;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_reg r, logic [23:0] v);
            case (r)
                REG_SIZE_X:   side[0] = 32'(v[10:0]);
                REG_SIZE_Y:   side[1] = 32'(v[10:0]);
                REG_SIZE_Z:   side[2] = 32'(v[10:0]);
                REG_SLAB_OFS: z_ofs = 32'(v[9:0]);
                REG_SCALE_X:  scale[0] = longint'(v);
                REG_SCALE_Y:  scale[1] = longint'(v);
                REG_SCALE_Z:  scale[2] = longint'(v);
                REG_NYQ_KILL: nyq_zero = v[0];
                default: ;
            endcase
        endfunction

        function void note_index(logic [IDX_W-1:0] idx);
            t_wv          e;
            longint       rest, n, c, f, w;
            bit           hit;
            logic [127:0] a;
            logic [127:0] sum;
            rest = longint'(idx);
            hit = 0;
            sum = 0;
            for (int d = 0; d < 3; d++) begin
                n = (side[d] == 0) ? 1 : (side[d] > 1024) ? 1024 : longint'(side[d]);
                if (d < 2) begin
                    c = rest % n;
                    rest = rest / n;
                end else begin
                    c = (rest + longint'(z_ofs)) % n;
                end
                if (n % 2 == 0 && c == n / 2) hit = 1;
                f = (2 * c < n) ? c : c - n;
                w = f * scale[d];
                e.freq[d] = 10'(f);
                e.wave[d] = WAVE_W'(w);
            end
            if (hit && nyq_zero) begin
                for (int d = 0; d < 3; d++) begin
                    e.freq[d] = 0;
                    e.wave[d] = 0;
                end
            end
            for (int d = 0; d < 3; d++) begin
                w = longint'(e.wave[d]);
                a = 128'((w < 0) ? -w : w);
                sum += (a * a) >> 16;
            end
            e.sq = sum[SQ_W-1:0];
            pending.push_back(e);
        endfunction

        function void check_word(t_wv got);
            t_wv   e;
            string ax[3];
            ax = '{"x", "y", "z"};
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int d = 0; d < 3; d++) begin
                if (got.freq[d] !== e.freq[d]) begin
                    $error("freq_%s: expected %0d, got %0d", ax[d], e.freq[d], got.freq[d]);
                    errors++;
                end
                if (got.wave[d] !== e.wave[d]) begin
                    $error("wave_%s: expected %0d, got %0d", ax[d], e.wave[d], got.wave[d]);
                    errors++;
                end
            end
            if (got.sq !== e.sq) begin
                $error("wave_sq: expected %0d, got %0d", e.sq, got.sq);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk = 0;
    logic                      i_rst_n = 0;
    logic                      i_cfg_we = 0;
    logic [2:0]                i_cfg_idx = '0;
    logic [23:0]               i_cfg_data = '0;
    logic                      i_valid = 0;
    logic                      o_ready;
    logic [IDX_W-1:0]          i_local_index = '0;
    logic                      o_valid;
    logic                      i_ready = 0;
    logic signed [9:0]         o_freq_x, o_freq_y, o_freq_z;
    logic signed [WAVE_W-1:0]  o_wave_x, o_wave_y, o_wave_z;
    logic [SQ_W-1:0]           o_wave_sq;

    wavevector_scoreboard sb = new();
    int unsigned cycles = 0;
    int unsigned hold_left = 0;
    bit          long_hold = 0;
    bit          no_stall = 0;

    fft_wavevector_from_index_core i_dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: check accepted words, then pick next ready
    always @(posedge i_clk) begin
        t_wv got;
        int  r;
        if (i_rst_n && o_valid && i_ready) begin
            got.freq = '{o_freq_x, o_freq_y, o_freq_z};
            got.wave = '{o_wave_x, o_wave_y, o_wave_z};
            got.sq   = o_wave_sq;
            sb.check_word(got);
        end
        if (long_hold) begin
            long_hold <= 0;
            hold_left <= 300;
            i_ready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 0;
        end else if (no_stall) begin
            i_ready <= 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) i_ready <= 1;
            else if (r < 97) i_ready <= 0;
            else begin
                i_ready <= 0;
                hold_left <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int r;
        if (no_stall) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called right after a rising edge
    task automatic send_index(logic [IDX_W-1:0] idx);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_local_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        sb.note_index(idx);
    endtask

    // called right after a rising edge
    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_reg r, logic [23:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= r;
        i_cfg_data <= v;
        sb.set_reg(r, v);
    endtask

    task automatic cfg_done();
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        longint span;
        if ($urandom_range(0, 3) == 0) return IDX_W'($urandom);
        span = longint'(sb.side[0] == 0 ? 1 : sb.side[0])
             * (sb.side[1] == 0 ? 1 : sb.side[1])
             * (sb.side[2] == 0 ? 1 : sb.side[2]);
        if (span > 64'h3FFF_FFFF) span = 64'h3FFF_FFFF;
        return IDX_W'($urandom_range(0, 32'(span - 1)));
    endfunction

    task automatic random_config();
        int unsigned s;
        for (int d = 0; d < 3; d++) begin
            case ($urandom_range(0, 5))
                0: s = 0;
                1: s = $urandom_range(1025, 2047);
                2: s = 1024;
                default: s = $urandom_range(1, 40);
            endcase
            cfg_write(t_cfg_reg'(REG_SIZE_X + d), 24'(s));
            case ($urandom_range(0, 4))
                0: s = 0;
                1: s = 24'hFFFFFF;
                default: s = $urandom_range(0, 24'hFFFFFF);
            endcase
            cfg_write(t_cfg_reg'(REG_SCALE_X + d), 24'(s));
        end
        cfg_write(REG_SLAB_OFS,
                  24'($urandom_range(0, 1) ? $urandom_range(0, 1023) : 1023));
        cfg_write(REG_NYQ_KILL, 24'($urandom_range(0, 1)));
        cfg_done();
    endtask

    initial begin
        logic [IDX_W-1:0] dir[$];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset settings: corners, Nyquist planes, wrap past the grid
        dir = '{0, 1, 31, 32, 33, 63, 64, 32*64, 32*4096, 4096*63 + 64*63 + 63,
                262143, 262144, 30'h3FFF_FFFF, 30'h2AAA_AAAA, 30'h1555_5555};
        foreach (dir[i]) send_index(dir[i]);
        drain();

        // Nyquist zeroing, even and odd sides, offset extremes
        cfg_write(REG_NYQ_KILL, 24'd1);
        cfg_write(REG_SIZE_X, 24'd4);
        cfg_write(REG_SIZE_Y, 24'd5);
        cfg_write(REG_SIZE_Z, 24'd8);
        cfg_write(REG_SLAB_OFS, 24'd1023);
        cfg_write(REG_SCALE_X, 24'hFFFFFF);
        cfg_write(REG_SCALE_Y, 24'd0);
        cfg_write(REG_SCALE_Z, 24'hFFFFFF);
        cfg_done();
        for (int i = 0; i < 10; i++) send_index(IDX_W'(i * 3));
        drain();

        // largest sides, biggest magnitudes
        cfg_write(REG_SIZE_X, 24'd2047);
        cfg_write(REG_SIZE_Y, 24'd1024);
        cfg_write(REG_SIZE_Z, 24'd0);
        cfg_write(REG_SLAB_OFS, 24'd0);
        cfg_write(REG_NYQ_KILL, 24'd0);
        cfg_done();
        send_index(30'd512);
        send_index(30'd513);
        send_index(30'(1023 + 1024 * 512));
        send_index(30'h3FFF_FFFF);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            random_config();
            no_stall = (ph == 4);
            for (int i = 0; i < 112; i++) begin
                if (ph == 2 && i == 20) long_hold = 1;
                send_index(pick_index());
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/fwv_pkg.sv
sv/fwv_divmod.sv
sv/fft_wavevector_from_index_core.sv
sim/fft_wavevector_from_index_core_tb.sv
